@@ src/hem_pkg.sv @@
// ----------------------------------------------------------------------------
// hem_pkg
// Shared widths, register indexes and state encoding for the histogram
// equalization table generator.
// ----------------------------------------------------------------------------
package hem_pkg;

  // Default width of the running sum and of the total count register.
  localparam int COUNT_BITS_DEF = 24;

  // Fixed field widths of the streams.
  localparam int BIN_COUNT_W = 24;
  localparam int IN_DATA_W   = 24;
  localparam int LEVEL_W     = 8;
  localparam int OUT_DATA_W  = 8;

  // Configuration register indexes.
  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] REG_TOTAL_COUNT  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_STRETCH_MODE = 1'b1;

  // Highest output level.
  localparam logic [LEVEL_W-1:0] MAX_LEVEL = 8'd255;

  // Sequencer states for one bin.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_NUM,
    ST_ADD,
    ST_DIV_C,
    ST_LEVEL,
    ST_STR_NUM,
    ST_STR_ADD,
    ST_DIV_S,
    ST_EMIT
  } hem_state_t;

endpackage

@@ src/histogram_equalization_map_top.sv @@
// ----------------------------------------------------------------------------
// histogram_equalization_map_top
// Turns histogram bin counts into equalization table entries, one per bin.
// ----------------------------------------------------------------------------
// Usage:
//   Bin counts arrive in ascending bin order on the in_ stream, one beat per
//   bin, with in_tlast on the final bin. Each input beat yields one out_ beat
//   carrying the table entry, out_tlast copied from the input and out_tuser
//   set when a stretch was asked for but the first bin already maps to 255.
//   The cfg_ port writes the total count (index 0) and the stretch mode
//   (index 1); write it only while no bin is in flight.
// Sequencing:
//   One bin is worked at a time. The next bin can be taken in the same
//   cycle that the previous result beat appears. The time per bin is set
//   by the bit-serial divider, which runs once per bin in classic mode and
//   twice in stretch mode, unless the first bin already maps to 255.
// Reset and stalls:
//   Reset clears the running sum, arms the first-bin capture and restores
//   the registers to total 1, classic mode. A result waits in the output
//   register while the receiver stalls; the next bin may be accepted and
//   worked meanwhile, and it waits for the output register to empty.
// ----------------------------------------------------------------------------
module histogram_equalization_map_top #(
  parameter int COUNT_BITS = hem_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input stream: tdata = bin_count[23:0]; tlast = last_bin
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [hem_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           in_tlast,
  // Result stream: tdata = map_value[7:0]; tlast = last_entry;
  // tuser = degenerate
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [hem_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tlast,
  output logic                           out_tuser,
  // Configuration write port
  input  logic                           cfg_we,
  input  logic [hem_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [COUNT_BITS-1:0]          cfg_wdata
);
  import hem_pkg::*;

  // Numerator width: 511 * total fits in COUNT_BITS + 9 bits.
  localparam int DW = COUNT_BITS + 9;

  hem_state_t          state_r;
  hem_state_t          state_nxt;
  logic [COUNT_BITS-1:0] total_r;
  logic                stretch_r;
  logic [COUNT_BITS-1:0] running_r;
  logic [LEVEL_W-1:0]  first_r;
  logic                at_first_r;
  logic                out_tvalid_r;
  logic [LEVEL_W-1:0]  out_data_r;
  logic                out_last_r;
  logic                out_degen_r;

  logic [COUNT_BITS-1:0] count_r;
  logic [COUNT_BITS-1:0] tot_r;
  logic                last_r;
  logic                mode_r;
  logic [DW-1:0]       num_r;
  logic [LEVEL_W-1:0]  classic_r;
  logic [LEVEL_W-1:0]  val_r;
  logic                degen_r;

  logic [COUNT_BITS-1:0] count_in;
  logic [COUNT_BITS:0]   sum_full;
  logic [COUNT_BITS-1:0] sum_sat;
  logic [LEVEL_W-1:0]  first_eff;
  logic [LEVEL_W-1:0]  diff_lvl;
  logic [LEVEL_W-1:0]  span;
  logic                div_start;
  logic [DW-1:0]       div_num;
  logic [DW-1:0]       div_den;
  logic                div_done;
  logic [LEVEL_W-1:0]  div_quot;
  logic                out_load;
  logic                in_beat;

  assign count_in = COUNT_BITS'(in_tdata[BIN_COUNT_W-1:0]);
  assign in_beat  = in_tvalid && in_tready;

  // Saturating running sum, and the stretch operands.
  always_comb begin
    sum_full  = {1'b0, running_r} + {1'b0, count_r};
    sum_sat   = (sum_full > {1'b0, tot_r}) ? tot_r : sum_full[COUNT_BITS-1:0];
    first_eff = at_first_r ? div_quot : first_r;
    diff_lvl  = (classic_r > first_r) ? (classic_r - first_r) : '0;
    span      = MAX_LEVEL - first_r;
  end

  // Sequencer: next state and strobes.
  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    div_num   = num_r + DW'(tot_r);
    div_den   = DW'({tot_r, 1'b0});
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_SUM;
      end
      ST_SUM: begin
        state_nxt = ST_NUM;
      end
      ST_NUM: begin
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        // round(510*sum + total) / (2*total)
        div_start = 1'b1;
        state_nxt = ST_DIV_C;
      end
      ST_DIV_C: begin
        if (div_done) state_nxt = ST_LEVEL;
      end
      ST_LEVEL: begin
        if (!mode_r || (first_eff == MAX_LEVEL)) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_STR_NUM;
        end
      end
      ST_STR_NUM: begin
        state_nxt = ST_STR_ADD;
      end
      ST_STR_ADD: begin
        // round(510*diff + span) / (2*span)
        div_start = 1'b1;
        div_num   = num_r + DW'(span);
        div_den   = DW'({span, 1'b0});
        state_nxt = ST_DIV_S;
      end
      ST_DIV_S: begin
        if (div_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_tvalid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state, configuration registers and sequence state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      total_r      <= COUNT_BITS'(1);
      stretch_r    <= 1'b0;
      running_r    <= '0;
      first_r      <= '0;
      at_first_r   <= 1'b1;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          REG_TOTAL_COUNT:  total_r   <= cfg_wdata;
          REG_STRETCH_MODE: stretch_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (state_r == ST_SUM) begin
        running_r <= sum_sat;
      end
      if ((state_r == ST_LEVEL) && at_first_r) begin
        first_r    <= div_quot;
        at_first_r <= 1'b0;
      end
      // The final bin restarts the sequence once its entry is out.
      if (out_load && last_r) begin
        running_r  <= '0;
        at_first_r <= 1'b1;
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Working registers of the bin in flight and the output register.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          count_r <= count_in;
          last_r  <= in_tlast;
          tot_r   <= (total_r == '0) ? COUNT_BITS'(1) : total_r;
          mode_r  <= stretch_r;
        end
      end
      ST_NUM: begin
        // 510 * sum, built as 512 * sum - 2 * sum.
        num_r <= DW'({running_r, 9'b0}) - DW'({running_r, 1'b0});
      end
      ST_LEVEL: begin
        classic_r <= div_quot;
        val_r     <= div_quot;
        degen_r   <= mode_r && (first_eff == MAX_LEVEL);
      end
      ST_STR_NUM: begin
        num_r <= DW'({diff_lvl, 9'b0}) - DW'({diff_lvl, 1'b0});
      end
      ST_DIV_S: begin
        if (div_done) val_r <= div_quot;
      end
      default: ;
    endcase
    if (out_load) begin
      out_data_r  <= val_r;
      out_last_r  <= last_r;
      out_degen_r <= degen_r;
    end
  end

  // Shared bit-serial divider.
  hem_div #(
    .W (DW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_degen_r;

endmodule

@@ src/hem_div.sv @@
// ----------------------------------------------------------------------------
// hem_div
// Bit-serial restoring divider producing an 8-bit quotient, one quotient bit
// per cycle. The caller guarantees the quotient fits in 8 bits.
// ----------------------------------------------------------------------------
module hem_div #(
  parameter int W = 33
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [W-1:0]                num,
  input  logic [W-1:0]                den,
  output logic                        done,
  output logic [hem_pkg::LEVEL_W-1:0] quot
);
  import hem_pkg::*;

  localparam int SW = W + LEVEL_W - 1;
  localparam int CW = $clog2(LEVEL_W);

  logic               busy_r;
  logic               done_r;
  logic [CW-1:0]      step_r;
  logic [W-1:0]       rem_r;
  logic [SW-1:0]      dsh_r;
  logic [LEVEL_W-1:0] quot_r;
  logic [SW-1:0]      rem_ext;
  logic [SW-1:0]      rem_diff;
  logic               fits;

  // Trial subtraction of the shifted divisor from the partial remainder.
  always_comb begin
    rem_ext  = SW'(rem_r);
    fits     = (rem_ext >= dsh_r);
    rem_diff = rem_ext - dsh_r;
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == CW'(LEVEL_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Remainder, divisor shift register and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      dsh_r <= {den, {(LEVEL_W - 1){1'b0}}};
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= rem_diff[W-1:0];
      end
      dsh_r  <= dsh_r >> 1;
      quot_r <= {quot_r[LEVEL_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

@@ src/hem_checker.sv @@
// ----------------------------------------------------------------------------
// hem_checker
// Port-level checks of the equalization table generator, bound to its top.
// ----------------------------------------------------------------------------
module hem_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [hem_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           out_tlast,
  input logic                           out_tuser
);
  import hem_pkg::*;

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output beat valid right after reset");

  // A stalled result beat holds its value.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled result beat changed");

  // One bin at a time: the input closes right after a beat is taken.
  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready again straight after a beat");

  // The input only closes because a beat was taken.
  a_close_on_beat: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(in_tvalid && in_tready))
    else $error("input ready dropped without a beat");

endmodule

bind histogram_equalization_map_top hem_checker u_hem_checker (.*);
